// File: hw/rtl/mtm_cal_pkg.sv
// mtm_cal_pkg: shared constants and types for the median trimmed mean calibrator
// no dependencies
`default_nettype none
package mtm_cal_pkg;
    localparam int SAMPLE_W = 12;
    localparam int MEAN_W   = 20;
    localparam int KEPT_W   = 7;
    localparam int TEMP_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 2'd2;

    localparam logic [SAMPLE_W-1:0] MAX_DELTA_RST = 12'd64;
    localparam logic signed [31:0] INTERCEPT_RST = -32'sd6640368;
    localparam logic signed [31:0] SLOPE_RST     = 32'sd1217182;

    // controls broadcast to every sort cell
    typedef struct packed {
        logic load;    // load the window copy
        logic odd;     // odd phase of odd-even transposition
    } mtm_cell_ctrl_t;
endpackage
`default_nettype wire

// File: hw/rtl/median_trimmed_mean_calibrator.sv
// channel | ports                                    | direction
// input   | s_valid s_ready s_sample                 | in
// result  | m_valid m_ready m_mean_q8 m_kept_count m_temperature_q16 | out
// config  | cfg_we cfg_index cfg_data                | in
// one word passes these steps from one accept to the next:
// DEPTH sort phases, the median step, trimming at the low and high ends, summing,
// divider start and divide (NUM_W = 20 + clog2(DEPTH + 1) bits), multiply, saturate, idle.
// reset (aresetn, synchronous, low) zeroes the window and loads register defaults.
// a result held by m_ready low keeps the block in its last step, so no new word is taken.
// top level: depends on mtm_cal_pkg, mtm_cal_cell, mtm_cal_div
`default_nettype none
module median_trimmed_mean_calibrator #(
    parameter int WINDOW_DEPTH = 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [mtm_cal_pkg::SAMPLE_W-1:0]     s_sample,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [mtm_cal_pkg::MEAN_W-1:0]            m_mean_q8,
    output logic [mtm_cal_pkg::KEPT_W-1:0]            m_kept_count,
    output logic signed [mtm_cal_pkg::TEMP_W-1:0]     m_temperature_q16,
    input  wire logic                                 cfg_we,
    input  wire logic [mtm_cal_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mtm_cal_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mtm_cal_pkg::*;
    localparam int N    = WINDOW_DEPTH;
    localparam int PW   = (N > 1) ? $clog2(N) : 1;
    localparam int CW   = $clog2(N + 1);
    localparam int HALF = N / 2;
    localparam int SUM_W = SAMPLE_W + CW;
    localparam int NUM_W = SUM_W + 8;

    localparam logic [3:0] ST_IDLE = 4'd0, ST_SORT = 4'd1, ST_MED = 4'd2, ST_LOW = 4'd3,
                           ST_HIGH = 4'd4, ST_SUM = 4'd5, ST_DSTART = 4'd6,
                           ST_DIV = 4'd7, ST_MUL = 4'd8, ST_SAT = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [SAMPLE_W-1:0] win_reg [N];
    logic [PW-1:0] wp_reg;
    logic [SAMPLE_W-1:0] max_delta_reg;
    logic signed [31:0] intercept_reg, slope_reg;
    logic [CW-1:0] cnt_reg, beg_reg, end_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SAMPLE_W:0] med2_reg;
    logic signed [52:0] prod_reg;
    logic out_valid_reg;
    logic [MEAN_W-1:0] mean_reg, out_mean_reg;
    logic [KEPT_W-1:0] kept_reg, out_kept_reg;
    logic signed [31:0] temp_reg, out_temp_reg;
    logic phase_reg;
    logic s_fire;
    logic out_free;

    mtm_cell_ctrl_t ctrl;
    logic [SAMPLE_W-1:0] cv [N];

    assign s_fire   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_ready;
    assign ctrl = '{load: s_fire, odd: phase_reg};

    // chain of sort cells, loaded with the window including the new word
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [SAMPLE_W-1:0] lv;
        assign lv = (wp_reg == PW'(g)) ? s_sample : win_reg[g];
        mtm_cal_cell u_cell (
            .aclk(aclk), .ctrl(ctrl), .cell_odd(1'(g % 2)),
            .has_left(g > 0), .has_right(g < N - 1),
            .load_val(lv),
            .left_val(cv[(g > 0) ? g - 1 : 0]),
            .right_val(cv[(g < N - 1) ? g + 1 : g]),
            .val(cv[g])
        );
    end

    // head elements for trim and sum scans: cells read at three moving indexes
    logic [SAMPLE_W-1:0] low_v, high_v, sum_v;
    logic [SAMPLE_W+1:0] dlow, dhigh;
    logic low_far, high_far;
    assign low_v  = cv[beg_reg[PW-1:0]];
    assign high_v = cv[end_reg[PW-1:0]];
    assign sum_v  = cv[cnt_reg[PW-1:0]];
    always_comb begin
        dlow  = ({1'b0, med2_reg} >= {low_v, 1'b0})
              ? {1'b0, med2_reg} - {1'b0, low_v, 1'b0}
              : {1'b0, low_v, 1'b0} - {1'b0, med2_reg};
        dhigh = ({1'b0, med2_reg} >= {high_v, 1'b0})
              ? {1'b0, med2_reg} - {1'b0, high_v, 1'b0}
              : {1'b0, high_v, 1'b0} - {1'b0, med2_reg};
        low_far  = dlow  > {1'b0, max_delta_reg, 1'b0};
        high_far = dhigh > {1'b0, max_delta_reg, 1'b0};
    end

    logic div_start, div_done;
    logic [NUM_W-1:0] quo;
    logic [CW-1:0] kept_w;
    assign kept_w = end_reg - beg_reg + 1'b1;
    mtm_cal_div #(.NUM_W(NUM_W), .DEN_W(CW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num({sum_reg, 8'd0}), .den(kept_w), .done(div_done), .quo(quo)
    );

    // sequencer
    logic signed [37:0] tsum;
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        tsum = 38'(prod_reg >>> 16) + 38'(intercept_reg);
        unique case (state_reg)
            ST_IDLE:   if (s_fire) state_next = ST_SORT;
            ST_SORT:   if (cnt_reg == CW'(N - 1)) state_next = ST_MED;
            ST_MED:    state_next = ST_LOW;
            ST_LOW:    if (beg_reg == CW'(HALF) || !low_far) state_next = ST_HIGH;
            ST_HIGH:   if (end_reg == CW'(HALF) || !high_far) state_next = ST_SUM;
            ST_SUM:    if (cnt_reg == end_reg) state_next = ST_DSTART;
            ST_DSTART: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:    if (div_done) state_next = ST_MUL;
            ST_MUL:    state_next = ST_SAT;
            ST_SAT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control state, window and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; wp_reg <= '0; out_valid_reg <= 1'b0;
            max_delta_reg <= MAX_DELTA_RST; intercept_reg <= INTERCEPT_RST;
            slope_reg <= SLOPE_RST; phase_reg <= 1'b0; cnt_reg <= '0;
            for (int i = 0; i < N; i++) win_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SAT && out_free) out_valid_reg <= 1'b1;
            else if (m_valid && m_ready) out_valid_reg <= 1'b0;
            // configuration writes
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_MAX_DELTA: max_delta_reg <= cfg_data[SAMPLE_W-1:0];
                    REG_INTERCEPT: intercept_reg <= cfg_data;
                    REG_SLOPE:     slope_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_fire) begin
                win_reg[wp_reg] <= s_sample;
                wp_reg <= (wp_reg == PW'(N - 1)) ? '0 : wp_reg + 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: if (s_fire) begin
                    phase_reg <= 1'b0; cnt_reg <= '0;
                end
                ST_SORT: begin
                    phase_reg <= ~phase_reg;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_HIGH: if (end_reg == CW'(HALF) || !high_far) cnt_reg <= beg_reg;
                ST_SUM: cnt_reg <= cnt_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_MED: begin
                if (N % 2 == 1) med2_reg <= {cv[HALF], 1'b0};
                else med2_reg <= {1'b0, cv[HALF - 1]} + {1'b0, cv[HALF]};
                beg_reg <= '0;
                end_reg <= CW'(N - 1);
            end
            ST_LOW: if (beg_reg != CW'(HALF) && low_far) beg_reg <= beg_reg + 1'b1;
            ST_HIGH: begin
                if (end_reg != CW'(HALF) && high_far) end_reg <= end_reg - 1'b1;
                sum_reg <= '0;
            end
            ST_SUM: sum_reg <= sum_reg + SUM_W'(sum_v);
            ST_DIV: if (div_done) begin
                mean_reg <= quo[MEAN_W-1:0];
                kept_reg <= KEPT_W'(kept_w);
                prod_reg <= 53'(slope_reg) * $signed({1'b0, quo[MEAN_W-1:0]});
            end
            ST_MUL: begin
                if (tsum > 38'sd2147483647) temp_reg <= 32'sh7fffffff;
                else if (tsum < -38'sd2147483648) temp_reg <= 32'sh80000000;
                else temp_reg <= tsum[31:0];
            end
            ST_SAT: if (out_free) begin
                out_mean_reg <= mean_reg;
                out_kept_reg <= kept_reg;
                out_temp_reg <= temp_reg;
            end
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_mean_q8 = out_mean_reg;
    assign m_kept_count = out_kept_reg;
    assign m_temperature_q16 = out_temp_reg;

`ifndef SYNTHESIS
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready) else $error("accepted word while busy");
    a_kept_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kept_count != '0)) else $error("empty kept count");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_mean_q8)) else $error("result changed");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/mtm_cal_cell.sv
// mtm_cal_cell: one cell of the odd-even transposition sort chain
// depends on mtm_cal_pkg
`default_nettype none
module mtm_cal_cell (
    input  wire logic                               aclk,
    input  wire mtm_cal_pkg::mtm_cell_ctrl_t        ctrl,
    input  wire logic                               cell_odd,
    input  wire logic                               has_left,
    input  wire logic                               has_right,
    input  wire logic [mtm_cal_pkg::SAMPLE_W-1:0]   load_val,
    input  wire logic [mtm_cal_pkg::SAMPLE_W-1:0]   left_val,
    input  wire logic [mtm_cal_pkg::SAMPLE_W-1:0]   right_val,
    output logic [mtm_cal_pkg::SAMPLE_W-1:0]        val
);
    import mtm_cal_pkg::*;
    logic [SAMPLE_W-1:0] val_reg, val_next;
    logic                pair_right;

    // in this phase the cell pairs with its right neighbor when its parity matches
    always_comb begin
        pair_right = (cell_odd == ctrl.odd);
        val_next = val_reg;
        if (ctrl.load) begin
            val_next = load_val;
        end else if (pair_right) begin
            if (has_right && right_val < val_reg) val_next = right_val;
        end else begin
            if (has_left && left_val > val_reg) val_next = left_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end
    assign val = val_reg;
endmodule
`default_nettype wire

// File: hw/rtl/mtm_cal_div.sv
// mtm_cal_div: restoring divider, one quotient bit per cycle
// depends on mtm_cal_pkg
`default_nettype none
module mtm_cal_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 7
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quo
);
    import mtm_cal_pkg::*;
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [DEN_W:0]   trial;

    // shift one numerator bit into the remainder, subtract if it fits
    always_comb begin
        q_next = q_reg; r_next = r_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; done_next = 1'b0;
        trial = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (start) begin
            q_next = num; r_next = '0; cnt_next = CNT_W'(NUM_W); busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
        q_reg <= q_next; r_reg <= r_next;
        if (start) d_reg <= den;
    end
    assign done = done_reg;
    assign quo  = q_reg;
endmodule
`default_nettype wire
